/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on the rising clock, off while reset is asserted.
`define SOT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Same check with a message of its own.
`define SOT_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`else

`define SOT_ASSERT(name, prop)
`define SOT_ASSERT_MSG(name, prop, msg)

`endif

`endif

/* rtl/sot_pkg.sv */
package sot_pkg;

  // Key weight of the time stamp: key = package + KeyScale * time
  localparam logic [16:0] KeyScale = 17'd100000;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RM_SCAN,
    S_INS_START,
    S_INS_SCAN,
    S_RESP,
    S_Q_CNT,
    S_Q_CNT_OUT,
    S_Q_RPT
  } state_e;

  // One stored table entry
  typedef struct packed {
    logic [36:0] key;
    logic [16:0] pkg;
    logic [19:0] stamp;
    logic        is_reg;
  } entry_t;

  // One request as taken from the input channel
  typedef struct packed {
    mode_e       mode;
    logic [16:0] pkg;
    logic [19:0] stamp;
    logic        is_reg;
    logic [19:0] qtime;
  } req_t;

  // One result item
  typedef struct packed {
    logic        kind;
    status_e     status;
    logic [5:0]  count;
    logic [16:0] pkg;
    logic [19:0] stamp;
    logic        is_reg;
    logic        last;
  } out_item_t;

endpackage

/* rtl/sot_mem.sv */
module sot_mem import sot_pkg::*; #(
  parameter int Depth = 32,
  parameter int IdxW  = 5
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  entry_t          wr_data_i,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output entry_t          rd_data_o
);

  entry_t mem_q [Depth];
  entry_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, holds its data while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/sot_seq.sv */
module sot_seq import sot_pkg::*; #(
  parameter int Depth = 32,
  parameter int IdxW  = 5,
  parameter int OccW  = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // request side
  input  logic            req_valid_i,
  input  req_t            req_i,
  output logic            req_ready_o,
  // result side
  input  logic            out_free_i,
  output logic            out_push_o,
  output out_item_t       out_item_o,
  // table memory
  output logic            mem_we_o,
  output logic [IdxW-1:0] mem_waddr_o,
  output entry_t          mem_wdata_o,
  output logic            mem_re_o,
  output logic [IdxW-1:0] mem_raddr_o,
  input  entry_t          mem_rdata_i
);

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [OccW-1:0] occ_q, occ_d;
  logic [OccW-1:0] cnt_q, cnt_d;
  logic            found_q, found_d;
  status_e         status_q, status_d;
  req_t            req_q;
  logic [36:0]     key_q;
  logic [36:0]     key_prod;
  logic            accept;
  logic            at_last;
  logic            hit;
  logic            in_range;
  entry_t          new_entry;

  assign accept   = req_valid_i && (state_q == S_IDLE);
  assign key_prod = 37'(req_i.stamp) * 37'(KeyScale);
  assign at_last  = ((OccW'(idx_q) + 1'b1) == occ_q);
  assign hit      = (mem_rdata_i.pkg == req_q.pkg) && !mem_rdata_i.is_reg;
  assign in_range = (mem_rdata_i.stamp <= req_q.qtime);

  assign new_entry = '{key: key_q, pkg: req_q.pkg, stamp: req_q.stamp,
                       is_reg: req_q.is_reg};

  // Capture the request and its sort key
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      key_q <= 37'(req_i.pkg) + key_prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      occ_q    <= '0;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      status_q <= STATUS_OK;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      occ_q    <= occ_d;
      cnt_q    <= cnt_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  // Sequencer: one table entry through the compare unit per cycle while the result side does not stall
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    occ_d       = occ_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = new_entry;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    out_push_o  = 1'b0;
    out_item_o  = '{kind: 1'b0, status: STATUS_OK, count: '0, pkg: '0,
                    stamp: '0, is_reg: 1'b0, last: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          found_d = 1'b0;
          idx_d   = '0;
          cnt_d   = '0;
          unique case (req_i.mode)
            MODE_INSERT: state_d = S_INS_START;
            MODE_UPDATE: begin
              if (occ_q == '0) begin
                state_d = S_INS_START;
              end else begin
                mem_re_o = 1'b1;
                state_d  = S_RM_SCAN;
              end
            end
            MODE_QUERY: begin
              if (occ_q == '0) begin
                state_d = S_Q_CNT_OUT;
              end else begin
                mem_re_o = 1'b1;
                state_d  = S_Q_CNT;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // Find the first removable entry, then close the gap behind it
      S_RM_SCAN: begin
        if (found_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_q - 1'b1;
          mem_wdata_o = mem_rdata_i;
        end
        found_d = found_q || hit;
        if (at_last) begin
          if (found_q || hit) begin
            occ_d = occ_q - 1'b1;
          end
          state_d = S_INS_START;
        end else begin
          idx_d       = idx_q + 1'b1;
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + 1'b1;
        end
      end

      S_INS_START: begin
        if (occ_q == OccW'(Depth)) begin
          status_d = STATUS_FULL;
          state_d  = S_RESP;
        end else begin
          if ((req_q.mode == MODE_UPDATE) && !found_q) begin
            status_d = STATUS_NOT_FOUND;
          end else begin
            status_d = STATUS_OK;
          end
          idx_d = IdxW'(occ_q);
          if (occ_q == '0) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = '0;
            occ_d       = occ_q + 1'b1;
            state_d     = S_RESP;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = IdxW'(occ_q - 1'b1);
            state_d     = S_INS_SCAN;
          end
        end
      end

      // Walk down from the top, shifting larger keys up by one slot
      S_INS_SCAN: begin
        mem_we_o = 1'b1;
        if ((idx_q == '0) || (mem_rdata_i.key <= key_q)) begin
          occ_d   = occ_q + 1'b1;
          state_d = S_RESP;
        end else begin
          mem_wdata_o = mem_rdata_i;
          idx_d       = idx_q - 1'b1;
          mem_re_o    = (idx_q > IdxW'(1));
          mem_raddr_o = idx_q - IdxW'(2);
        end
      end

      S_RESP: begin
        if (out_free_i) begin
          out_push_o        = 1'b1;
          out_item_o.status = status_q;
          state_d           = S_IDLE;
        end
      end

      // Count entries at or below the query time
      S_Q_CNT: begin
        if (in_range) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (at_last) begin
          state_d = S_Q_CNT_OUT;
        end else begin
          idx_d       = idx_q + 1'b1;
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + 1'b1;
        end
      end

      S_Q_CNT_OUT: begin
        if (out_free_i) begin
          out_push_o       = 1'b1;
          out_item_o.count = 6'(cnt_q);
          out_item_o.last  = (cnt_q == '0);
          if (cnt_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d    = '0;
            mem_re_o = 1'b1;
            state_d  = S_Q_RPT;
          end
        end
      end

      // Report matching entries; cnt_q counts the ones still to go
      S_Q_RPT: begin
        if (!in_range || out_free_i) begin
          if (in_range) begin
            out_push_o        = 1'b1;
            out_item_o.kind   = 1'b1;
            out_item_o.pkg    = mem_rdata_i.pkg;
            out_item_o.stamp  = mem_rdata_i.stamp;
            out_item_o.is_reg = mem_rdata_i.is_reg;
            out_item_o.last   = (cnt_q == OccW'(1));
            cnt_d             = cnt_q - 1'b1;
          end
          if (in_range && (cnt_q == OccW'(1))) begin
            state_d = S_IDLE;
          end else begin
            idx_d       = idx_q + 1'b1;
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_q + 1'b1;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);

endmodule

/* rtl/sorted_event_table.sv */
// Channel   Dir  Width  Contents
// s_axis    in   64+2   one request: insert, update or query
// m_axis    out  48+1   status, count or reported entry; tlast on the final one
//
// Insert: a scan down from the top shifts each larger key up; no scan if empty or full.
// Update: one pass over the table to remove, then the insert.
// Query: a count pass and a report pass over the table. Table entries are read
// one per cycle while the output does not stall.
// Reset empties the table at once; no clearing pass. The input is not ready
// while an item is at work; an output stall only holds the sequencer.
`include "assert_macros.svh"

module sorted_event_table import sot_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [16:0] package_id, [36:17] event_time, [37] is_registration,
  // [57:38] query_time, [63:58] zero
  input  logic [63:0] s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [7:2] match_count, [24:8] entry_package,
  // [44:25] entry_stamp, [45] entry_is_registration, [47:46] zero
  output logic [47:0] m_axis_tdata,
  // [0] kind
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int OccW = $clog2(TABLE_DEPTH + 1);

  req_t            req;
  logic            out_free;
  logic            out_push;
  out_item_t       out_item;
  logic            out_valid_q;
  out_item_t       out_item_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  entry_t          mem_rdata;

  // Unpack the request transaction
  assign req.mode   = mode_e'(s_axis_tuser);
  assign req.pkg    = s_axis_tdata[16:0];
  assign req.stamp  = s_axis_tdata[36:17];
  assign req.is_reg = s_axis_tdata[37];
  assign req.qtime  = s_axis_tdata[57:38];

  sot_seq #(
    .Depth (TABLE_DEPTH),
    .IdxW  (IdxW),
    .OccW  (OccW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_i       (req),
    .req_ready_o (s_axis_tready),
    .out_free_i  (out_free),
    .out_push_o  (out_push),
    .out_item_o  (out_item),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  sot_mem #(
    .Depth (TABLE_DEPTH),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  // Output register: free when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_item_q <= out_item;
    end
  end

  // Pack the result transaction
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_item_q.kind;
  assign m_axis_tlast  = out_item_q.last;
  assign m_axis_tdata  = {2'b00, out_item_q.is_reg, out_item_q.stamp, out_item_q.pkg,
                          out_item_q.count, out_item_q.status};

  `SOT_ASSERT_MSG(a_push_into_free, out_push |-> out_free, "result pushed over a held one")
  `SOT_ASSERT(a_no_push_idle, s_axis_tready |-> !out_push)
  `SOT_ASSERT(a_count_nz, (out_push && !out_item.kind && !out_item.last) |-> |out_item.count)

endmodule
